/* rtl/rkde_pkg.sv */
package rkde_pkg;

  localparam int EXP_TABLE_DEPTH = 64;
  localparam int TAB_W = $clog2(EXP_TABLE_DEPTH + 1);
  localparam longint unsigned LN2_Q30 = 64'd744261118;
  localparam int LOG2_10_Q16 = 217706;

  localparam int DIV_NUM_W = 33;
  localparam int DIV_DEN_W = 25;

  localparam logic [1:0] CFG_NOISE = 2'd0;
  localparam logic [1:0] CFG_TX_POWER = 2'd1;
  localparam logic [1:0] CFG_NEAR = 2'd2;
  localparam logic [1:0] CFG_FAR = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KSTART,
    ST_KWAIT,
    ST_KMUL,
    ST_KUPD,
    ST_DPREP,
    ST_DSTART,
    ST_DWAIT,
    ST_EXP0,
    ST_EXP1,
    ST_EXP2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic div_kalman;
    logic k_load;
    logic kmul;
    logic kupd;
    logic dprep;
    logic dfix;
    logic exp0;
    logic exp1;
    logic exp2;
    logic sel;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } status_t;

  // 2^(idx/EXP_TABLE_DEPTH) in Q30 from a truncated exponential series.
  function automatic logic [31:0] pow2_point(input int idx);
    longint unsigned y;
    longint unsigned term;
    longint unsigned sum;
    y = longint'(idx) * LN2_Q30 / EXP_TABLE_DEPTH;
    term = 64'd1 << 30;
    sum = term;
    term = ((term * y) >> 30) / 1;  sum = sum + term;
    term = ((term * y) >> 30) / 2;  sum = sum + term;
    term = ((term * y) >> 30) / 3;  sum = sum + term;
    term = ((term * y) >> 30) / 4;  sum = sum + term;
    term = ((term * y) >> 30) / 5;  sum = sum + term;
    term = ((term * y) >> 30) / 6;  sum = sum + term;
    term = ((term * y) >> 30) / 7;  sum = sum + term;
    term = ((term * y) >> 30) / 8;  sum = sum + term;
    term = ((term * y) >> 30) / 9;  sum = sum + term;
    term = ((term * y) >> 30) / 10; sum = sum + term;
    term = ((term * y) >> 30) / 11; sum = sum + term;
    term = ((term * y) >> 30) / 12; sum = sum + term;
    term = ((term * y) >> 30) / 13; sum = sum + term;
    term = ((term * y) >> 30) / 14; sum = sum + term;
    return sum[31:0];
  endfunction

endpackage

/* rtl/rssi_kalman_distance_estimator.sv */
// Channel  Handshake               Payload
// in       in_valid / in_ready     raw_rssi
// out      out_valid / out_ready   filtered_rssi, kalman_gain, error_variance,
//                                  raw_distance, filtered_distance
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A request is carried through in full before the next one is taken, and the next
// request is taken once the result has moved to the output register: a shared 33-step
// restoring divider runs three times (Kalman gain, then one distance division per RSSI value).
// A finished result sits in the output register while the next request is taken;
// a second result waits in the controller until the first one is taken.
// Synchronous reset restores the register defaults and the initial estimate.
// Configuration writes are always accepted.
module rssi_kalman_distance_estimator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [7:0]  raw_rssi,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] filtered_rssi,
  output logic [16:0]        kalman_gain,
  output logic [16:0]        error_variance,
  output logic [31:0]        raw_distance,
  output logic [31:0]        filtered_distance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  rkde_pkg::cmd_t cmd;
  rkde_pkg::status_t status;

  assign cfg_ready = 1'b1;

  rkde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rkde_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .raw_rssi         (raw_rssi),
    .filtered_rssi    (filtered_rssi),
    .kalman_gain      (kalman_gain),
    .error_variance   (error_variance),
    .raw_distance     (raw_distance),
    .filtered_distance(filtered_distance)
  );

endmodule

/* rtl/rkde_div.sv */
module rkde_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [rkde_pkg::DIV_NUM_W-1:0]     num,
  input  logic [rkde_pkg::DIV_DEN_W-1:0]     den,
  output logic                               busy,
  output logic [rkde_pkg::DIV_NUM_W-1:0]     quo,
  output logic [rkde_pkg::DIV_DEN_W-1:0]     rem
);

  localparam int CNT_W = $clog2(rkde_pkg::DIV_NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [rkde_pkg::DIV_DEN_W-1:0] den_r;
  logic [rkde_pkg::DIV_DEN_W:0] trial;
  logic take;

  // Restoring division: the numerator shifts out of quo while quotient bits shift in.
  assign trial = {rem, quo[rkde_pkg::DIV_NUM_W-1]};
  assign take = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      busy <= 1'b0;
    end else if (start) begin
      cnt <= CNT_W'(rkde_pkg::DIV_NUM_W);
      busy <= 1'b1;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      busy <= (cnt != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      den_r <= den;
    end else if (busy) begin
      quo <= {quo[rkde_pkg::DIV_NUM_W-2:0], take};
      rem <= take ? rkde_pkg::DIV_DEN_W'(trial - {1'b0, den_r})
                  : trial[rkde_pkg::DIV_DEN_W-1:0];
    end
  end

endmodule

/* rtl/rkde_ctrl.sv */
module rkde_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  rkde_pkg::status_t status,
  output rkde_pkg::cmd_t   cmd
);

  rkde_pkg::state_t state, state_next;
  logic sel, sel_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rkde_pkg::ST_IDLE;
      sel <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sel <= sel_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next = sel;
    cmd = '0;
    cmd.sel = sel;
    in_ready = 1'b0;
    case (state)
      rkde_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = rkde_pkg::ST_KSTART;
        end
      end
      rkde_pkg::ST_KSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_kalman = 1'b1;
        state_next = rkde_pkg::ST_KWAIT;
      end
      rkde_pkg::ST_KWAIT: begin
        if (!status.div_busy) begin
          cmd.k_load = 1'b1;
          state_next = rkde_pkg::ST_KMUL;
        end
      end
      rkde_pkg::ST_KMUL: begin
        cmd.kmul = 1'b1;
        state_next = rkde_pkg::ST_KUPD;
      end
      rkde_pkg::ST_KUPD: begin
        cmd.kupd = 1'b1;
        sel_next = 1'b0;
        state_next = rkde_pkg::ST_DPREP;
      end
      rkde_pkg::ST_DPREP: begin
        cmd.dprep = 1'b1;
        state_next = rkde_pkg::ST_DSTART;
      end
      rkde_pkg::ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_next = rkde_pkg::ST_DWAIT;
      end
      rkde_pkg::ST_DWAIT: begin
        if (!status.div_busy) begin
          cmd.dfix = 1'b1;
          state_next = rkde_pkg::ST_EXP0;
        end
      end
      rkde_pkg::ST_EXP0: begin
        cmd.exp0 = 1'b1;
        state_next = rkde_pkg::ST_EXP1;
      end
      rkde_pkg::ST_EXP1: begin
        cmd.exp1 = 1'b1;
        state_next = rkde_pkg::ST_EXP2;
      end
      rkde_pkg::ST_EXP2: begin
        cmd.exp2 = 1'b1;
        if (sel) begin
          state_next = rkde_pkg::ST_DONE;
        end else begin
          sel_next = 1'b1;
          state_next = rkde_pkg::ST_DPREP;
        end
      end
      rkde_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next = rkde_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rkde_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

/* rtl/rkde_datapath.sv */
module rkde_datapath (
  input  logic                clk,
  input  logic                rst,
  input  rkde_pkg::cmd_t      cmd,
  output rkde_pkg::status_t   status,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic signed [7:0]   raw_rssi,
  output logic signed [15:0]  filtered_rssi,
  output logic [16:0]         kalman_gain,
  output logic [16:0]         error_variance,
  output logic [31:0]         raw_distance,
  output logic [31:0]         filtered_distance
);

  localparam int TW = rkde_pkg::TAB_W;
  localparam int POS_W = 16 + TW;

  // Configuration registers.
  logic [23:0] noise;
  logic signed [15:0] tx_power;
  logic [7:0] near_div;
  logic [7:0] far_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise <= 24'd66;
      tx_power <= -16'sd11648;
      near_div <= 8'd17;
      far_div <= 8'd25;
    end else if (cfg_valid) begin
      case (cfg_index)
        rkde_pkg::CFG_NOISE: noise <= cfg_data;
        rkde_pkg::CFG_TX_POWER: tx_power <= cfg_data[15:0];
        rkde_pkg::CFG_NEAR: near_div <= cfg_data[7:0];
        rkde_pkg::CFG_FAR: far_div <= cfg_data[7:0];
        default: noise <= noise;
      endcase
    end
  end

  // Filter state.
  logic signed [15:0] est;
  logic [16:0] var_p;
  logic signed [15:0] raw_q;
  logic [16:0] k;
  logic signed [35:0] prod_e;
  logic [33:0] prod_p;

  // Shared divider.
  logic [rkde_pkg::DIV_NUM_W-1:0] div_num, div_quo;
  logic [rkde_pkg::DIV_DEN_W-1:0] div_den, div_rem;
  logic div_busy;
  logic [rkde_pkg::DIV_DEN_W-1:0] k_den;

  // Distance path.
  logic signed [35:0] prod_d;
  logic [7:0] n_q;
  logic signed [28:0] e_q;
  logic sat_q;
  logic signed [12:0] ip_q;
  logic [31:0] lo_q;
  logic [31:0] span_q;
  logic [15:0] rem_q;
  logic [47:0] mprod;
  logic [31:0] raw_dist_q, filt_dist_q;

  assign k_den = rkde_pkg::DIV_DEN_W'(var_p) + rkde_pkg::DIV_DEN_W'(noise);

  // Distance operands for the divider.
  logic signed [27:0] dd_a;
  logic [26:0] dd_mag;
  logic dd_neg;
  assign dd_neg = prod_d[35];
  assign dd_a = prod_d[35:8];
  assign dd_mag = dd_neg ? 27'(-dd_a) : dd_a[26:0];

  always_comb begin
    if (cmd.div_kalman) begin
      div_num = {var_p, 16'b0};
      div_den = k_den;
    end else begin
      div_num = rkde_pkg::DIV_NUM_W'(dd_mag);
      div_den = rkde_pkg::DIV_DEN_W'(n_q);
    end
  end

  rkde_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  assign status.div_busy = div_busy;

  // Kalman update.
  logic signed [17:0] diff;
  logic signed [35:0] upd_sum;
  assign diff = 18'(raw_q) - 18'(est);
  assign upd_sum = prod_e + 36'sd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      est <= 16'sd512;
      var_p <= 17'd65536;
    end else if (cmd.kupd) begin
      est <= est + upd_sum[31:16];
      var_p <= prod_p[32:16];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw_q <= {raw_rssi, 8'b0};
    end
    if (cmd.k_load) begin
      // A zero denominator only happens with zero variance and zero noise.
      k <= (k_den == '0) ? 17'd0 : div_quo[16:0];
    end
    if (cmd.kmul) begin
      prod_e <= $signed({1'b0, k}) * diff;
      prod_p <= (17'd65536 - k) * var_p;
    end
  end

  // Distance preparation.
  logic signed [15:0] dsrc;
  logic signed [16:0] dist_d;
  logic [7:0] n_sel;
  assign dsrc = cmd.sel ? est : raw_q;
  assign dist_d = 17'(tx_power) - 17'(dsrc);
  assign n_sel = (dsrc >= tx_power) ? near_div : far_div;

  // Floor division fixup and exponent.
  logic [27:0] q_up;
  logic signed [28:0] q_f;
  assign q_up = 28'(div_quo[26:0]) + 28'(div_rem != '0);
  assign q_f = dd_neg ? -29'(q_up) : 29'(div_quo[26:0]);

  // Table lookup with linear interpolation.
  logic [31:0] exp_tab [0:rkde_pkg::EXP_TABLE_DEPTH];
  for (genvar g = 0; g <= rkde_pkg::EXP_TABLE_DEPTH; g++) begin : g_tab
    assign exp_tab[g] = rkde_pkg::pow2_point(g);
  end

  logic [POS_W-1:0] pos;
  logic [TW-1:0] idx_lo, idx_hi;
  assign pos = POS_W'(e_q[15:0]) * POS_W'(rkde_pkg::EXP_TABLE_DEPTH);
  assign idx_lo = pos[POS_W-1:16];
  assign idx_hi = idx_lo + 1'b1;

  // Scale the mantissa by the integer power with round half up.
  logic [32:0] mant;
  logic signed [12:0] sh;
  logic [34:0] rnd;
  logic [34:0] scaled;
  logic [31:0] dist_val;
  assign mant = 33'(lo_q) + 33'(mprod[47:16]);
  assign sh = 13'sd30 - ip_q;
  assign rnd = (35'(mant) + (35'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];

  always_comb begin
    if (ip_q >= 13'sd30) begin
      scaled = 35'(mant) << ip_q[0];
    end else if (ip_q < -13'sd3) begin
      scaled = '0;
    end else begin
      scaled = rnd;
    end
    if (sat_q || scaled > 35'h0FFFFFFFF) begin
      dist_val = 32'hFFFFFFFF;
    end else begin
      dist_val = scaled[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dprep) begin
      prod_d <= 36'(dist_d) * 36'(rkde_pkg::LOG2_10_Q16);
      n_q <= (n_sel == 8'd0) ? 8'd1 : n_sel;
    end
    if (cmd.dfix) begin
      e_q <= q_f + 29'sd524288;
    end
    if (cmd.exp0) begin
      sat_q <= e_q >= 29'sd2097152;
      ip_q <= e_q[28:16];
      lo_q <= exp_tab[idx_lo];
      span_q <= exp_tab[idx_hi] - exp_tab[idx_lo];
      rem_q <= pos[15:0];
    end
    if (cmd.exp1) begin
      mprod <= span_q * rem_q;
    end
    if (cmd.exp2) begin
      if (cmd.sel) begin
        filt_dist_q <= dist_val;
      end else begin
        raw_dist_q <= dist_val;
      end
    end
    if (cmd.load_out) begin
      filtered_rssi <= est;
      kalman_gain <= k;
      error_variance <= var_p;
      raw_distance <= raw_dist_q;
      filtered_distance <= filt_dist_q;
    end
  end

endmodule
